/* design/bfp_pkg.sv */
package bfp_pkg;

  // Parse phase codes
  localparam logic [2:0] PhHunt = 3'd0;
  localparam logic [2:0] PhIds  = 3'd1;
  localparam logic [2:0] PhLen  = 3'd2;
  localparam logic [2:0] PhData = 3'd3;
  localparam logic [2:0] PhCsum = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CfgHeaderByte = 2'd0;
  localparam logic [1:0] CfgMaxLen     = 2'd1;

  // Reset values of the configuration registers
  localparam logic [7:0] HeaderByteRst = 8'd170;
  localparam logic [8:0] MaxLenRst     = 9'd64;

  // Number of identifier bytes after the header
  localparam logic [8:0] IdBytes = 9'd4;

  // Result kinds
  localparam logic KindPayload = 1'b0;
  localparam logic KindVerdict = 1'b1;

  // Frame status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusMismatch = 2'd1;
  localparam logic [1:0] StatusRejected = 2'd2;

  // One result word
  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] node_id;
    logic [7:0] net_id;
    logic [7:0] message_id;
    logic [7:0] sequence_number;
    logic [7:0] frame_payload_len;
    logic [7:0] received_checksum;
    logic [7:0] computed_checksum;
    logic [1:0] frame_status;
  } bfp_result_t;

endpackage

/* design/binary_frame_parser.sv */
// A result word is registered and appears on the output in the cycle after the byte that causes it.
// Throughput: one byte per cycle; input ready drops only while a result word waits
// in the output register and the consumer does not take it.
// Reset: asynchronous, active low; returns to hunting for the header, clears the
// counters, running sum and held fields, and restores both configuration registers.
module binary_frame_parser
  import bfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [8:0] cfg_data_i,
  // Input byte channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  // Result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       result_kind_o,
  output logic [7:0] payload_byte_o,
  output logic [7:0] payload_index_o,
  output logic [7:0] node_id_o,
  output logic [7:0] net_id_o,
  output logic [7:0] message_id_o,
  output logic [7:0] sequence_number_o,
  output logic [7:0] frame_payload_len_o,
  output logic [7:0] received_checksum_o,
  output logic [7:0] computed_checksum_o,
  output logic [1:0] frame_status_o
);

  logic [7:0]  header_q;
  logic [8:0]  max_len_q;
  logic [2:0]  phase_q, phase_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  dev_q, dev_d;
  logic [7:0]  sys_q, sys_d;
  logic [7:0]  msg_q, msg_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  len_q, len_d;
  logic        out_valid_q, out_valid_d;
  bfp_result_t result_q, result_d;
  logic        emit;
  logic        accept;
  logic [8:0]  cnt_inc;
  logic [7:0]  sum_add;

  // Configuration is always taken at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= HeaderByteRst;
      max_len_q <= MaxLenRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgHeaderByte) begin
        header_q <= cfg_data_i[7:0];
      end else if (cfg_index_i == CfgMaxLen) begin
        max_len_q <= cfg_data_i;
      end
    end
  end

  // A new byte is taken whenever the output register is free or is being emptied.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign cnt_inc = {1'b0, cnt_q} + 9'd1;
  assign sum_add = sum_q + data_byte_i;

  // Per-byte parser step.
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    dev_d    = dev_q;
    sys_d    = sys_q;
    msg_d    = msg_q;
    seq_d    = seq_q;
    len_d    = len_q;
    emit     = 1'b0;
    result_d = '0;

    unique case (phase_q)
      PhHunt: begin
        if (data_byte_i == header_q) begin
          phase_d = PhIds;
          cnt_d   = '0;
          sum_d   = header_q;
        end
      end
      PhIds: begin
        case (cnt_q)
          8'd0:    dev_d = data_byte_i;
          8'd1:    sys_d = data_byte_i;
          8'd2:    msg_d = data_byte_i;
          default: seq_d = data_byte_i;
        endcase
        sum_d = sum_add;
        cnt_d = cnt_inc[7:0];
        if (cnt_inc >= IdBytes) begin
          phase_d = PhLen;
        end
      end
      PhLen: begin
        len_d = data_byte_i;
        sum_d = sum_add;
        if ({1'b0, data_byte_i} >= max_len_q) begin
          // Length too large: verdict on the length byte itself.
          phase_d                    = PhHunt;
          emit                       = 1'b1;
          result_d.kind              = KindVerdict;
          result_d.computed_checksum = sum_add;
          result_d.frame_status      = StatusRejected;
        end else if (data_byte_i == 8'd0) begin
          phase_d = PhCsum;
        end else begin
          phase_d = PhData;
          cnt_d   = '0;
        end
      end
      PhData: begin
        sum_d = sum_add;
        cnt_d = cnt_inc[7:0];
        if (cnt_inc >= {1'b0, len_q}) begin
          phase_d = PhCsum;
        end
        emit                   = 1'b1;
        result_d.kind          = KindPayload;
        result_d.payload_byte  = data_byte_i;
        result_d.payload_index = cnt_q;
      end
      PhCsum: begin
        phase_d                    = PhHunt;
        emit                       = 1'b1;
        result_d.kind              = KindVerdict;
        result_d.received_checksum = data_byte_i;
        result_d.computed_checksum = sum_q;
        result_d.frame_status      = (data_byte_i == sum_q) ? StatusOk : StatusMismatch;
      end
      default: begin
        phase_d = PhHunt;
      end
    endcase

    // The header fields travel in both kinds of result.
    result_d.node_id           = dev_d;
    result_d.net_id            = sys_d;
    result_d.message_id        = msg_d;
    result_d.sequence_number   = seq_d;
    result_d.frame_payload_len = len_d;
  end

  // Parser state advances only on an accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      cnt_q   <= '0;
      sum_q   <= '0;
      dev_q   <= '0;
      sys_q   <= '0;
      msg_q   <= '0;
      seq_q   <= '0;
      len_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      dev_q   <= dev_d;
      sys_q   <= sys_d;
      msg_q   <= msg_d;
      seq_q   <= seq_d;
      len_q   <= len_d;
    end
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output register word; loaded only when a byte produces a result.
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign result_kind_o       = result_q.kind;
  assign payload_byte_o      = result_q.payload_byte;
  assign payload_index_o     = result_q.payload_index;
  assign node_id_o           = result_q.node_id;
  assign net_id_o            = result_q.net_id;
  assign message_id_o        = result_q.message_id;
  assign sequence_number_o   = result_q.sequence_number;
  assign frame_payload_len_o = result_q.frame_payload_len;
  assign received_checksum_o = result_q.received_checksum;
  assign computed_checksum_o = result_q.computed_checksum;
  assign frame_status_o      = result_q.frame_status;

`ifndef SYNTH
  // A passing verdict must have matching checksums.
  a_ok_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.kind == KindVerdict && result_q.frame_status == StatusOk
    |-> result_q.received_checksum == result_q.computed_checksum)
    else $error("ok verdict with differing checksums");

  // A mismatch verdict must have differing checksums.
  a_bad_differs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.kind == KindVerdict && result_q.frame_status == StatusMismatch
    |-> result_q.received_checksum != result_q.computed_checksum)
    else $error("mismatch verdict with equal checksums");

  // Payload words stay inside the announced length.
  a_index_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.kind == KindPayload
    |-> result_q.payload_index < result_q.frame_payload_len)
    else $error("payload index beyond frame length");

  // A rejected frame carries no received checksum.
  a_reject_no_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.kind == KindVerdict && result_q.frame_status == StatusRejected
    |-> result_q.received_checksum == 8'd0)
    else $error("rejected verdict with a received checksum");

  // The parser is never in the payload phase with a zero length.
  a_data_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhData |-> len_q != 8'd0 && cnt_q < len_q)
    else $error("payload phase with exhausted length");
`endif

endmodule

/* dv/binary_frame_parser_tb.sv */
`timescale 1ns / 100ps

module binary_frame_parser_tb;
  import bfp_pkg::*;

  // Cycles of silence after the last result before the block counts as idle.
  localparam int SettleCycles = 4;

  // Register indexes that the block does not implement.
  localparam logic [1:0] CfgUnusedLo = 2'd2;
  localparam logic [1:0] CfgUnusedHi = 2'd3;

  typedef enum logic [1:0] {PlanByte, PlanCfg, PlanPause} plan_kind_e;
  typedef enum int {SumGood, SumBad, SumAny} sum_mode_e;

  typedef struct {
    plan_kind_e kind;
    logic [1:0] idx;
    logic [8:0] val;
    bit         calm;
  } plan_entry_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [8:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       result_kind_o;
  logic [7:0] payload_byte_o;
  logic [7:0] payload_index_o;
  logic [7:0] node_id_o;
  logic [7:0] net_id_o;
  logic [7:0] message_id_o;
  logic [7:0] sequence_number_o;
  logic [7:0] frame_payload_len_o;
  logic [7:0] received_checksum_o;
  logic [7:0] computed_checksum_o;
  logic [1:0] frame_status_o;

  binary_frame_parser DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_kind_o      (result_kind_o),
    .payload_byte_o     (payload_byte_o),
    .payload_index_o    (payload_index_o),
    .node_id_o          (node_id_o),
    .net_id_o           (net_id_o),
    .message_id_o       (message_id_o),
    .sequence_number_o  (sequence_number_o),
    .frame_payload_len_o(frame_payload_len_o),
    .received_checksum_o(received_checksum_o),
    .computed_checksum_o(computed_checksum_o),
    .frame_status_o     (frame_status_o)
  );

  // Stimulus plan and expected result words.
  plan_entry_t tx_plan[$];
  bfp_result_t expected_words[$];

  // Shadow of the configuration and of the parser state.
  logic [7:0] cfg_hdr;
  logic [8:0] cfg_max;
  logic [2:0] fr_phase;
  logic [7:0] fr_count;
  logic [7:0] fr_sum;
  logic [7:0] seen_dev;
  logic [7:0] seen_sys;
  logic [7:0] seen_msg;
  logic [7:0] seen_seq;
  logic [7:0] seen_len;

  // Handshake bookkeeping of the driver and the monitor.
  int words_due;
  int words_seen;
  int quiet_cycles;
  int send_gap;
  int recv_stall;
  bit calm_phase;
  bit plan_done;

  // Generator state while the plan is built.
  logic [7:0] gen_hdr;
  logic [8:0] gen_max;
  logic [7:0] gen_sum;
  bit         gen_calm;
  int         n_planned;

  // Tallies for the summary.
  int err_cnt;
  int n_bytes;
  int n_cfg;
  int n_payload;
  int n_ok;
  int n_bad;
  int n_rej;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // A result word carries the identifiers and length of the current frame.
  function automatic bfp_result_t make_word(logic kind, logic [7:0] pbyte, logic [7:0] pidx,
                                            logic [7:0] rx, logic [7:0] calc,
                                            logic [1:0] status);
    bfp_result_t w;
    w.kind              = kind;
    w.payload_byte      = pbyte;
    w.payload_index     = pidx;
    w.node_id           = seen_dev;
    w.net_id            = seen_sys;
    w.message_id        = seen_msg;
    w.sequence_number   = seen_seq;
    w.frame_payload_len = seen_len;
    w.received_checksum = rx;
    w.computed_checksum = calc;
    w.frame_status      = status;
    return w;
  endfunction

  // Advance the frame shadow by one accepted byte and queue any word it causes.
  task automatic track_frame_byte(input logic [7:0] b, output int made);
    made = 0;
    case (fr_phase)
      PhHunt: begin
        if (b == cfg_hdr) begin
          fr_phase = PhIds;
          fr_count = '0;
          fr_sum   = cfg_hdr;
        end
      end
      PhIds: begin
        case (fr_count)
          8'd0:    seen_dev = b;
          8'd1:    seen_sys = b;
          8'd2:    seen_msg = b;
          default: seen_seq = b;
        endcase
        fr_sum   = fr_sum + b;
        fr_count = fr_count + 8'd1;
        if ({1'b0, fr_count} >= IdBytes) fr_phase = PhLen;
      end
      PhLen: begin
        seen_len = b;
        fr_sum   = fr_sum + b;
        if ({1'b0, b} >= cfg_max) begin
          // The verdict for an oversized frame comes on the length byte itself.
          fr_phase = PhHunt;
          expected_words.push_back(make_word(KindVerdict, '0, '0, '0, fr_sum, StatusRejected));
          made = 1;
        end else if (b == 8'd0) begin
          fr_phase = PhCsum;
        end else begin
          fr_phase = PhData;
          fr_count = '0;
        end
      end
      PhData: begin
        expected_words.push_back(make_word(KindPayload, b, fr_count, '0, '0, StatusOk));
        made     = 1;
        fr_sum   = fr_sum + b;
        fr_count = fr_count + 8'd1;
        if (fr_count >= seen_len) fr_phase = PhCsum;
      end
      PhCsum: begin
        fr_phase = PhHunt;
        expected_words.push_back(make_word(KindVerdict, '0, '0, b, fr_sum,
                                           (b == fr_sum) ? StatusOk : StatusMismatch));
        made = 1;
      end
      default: begin
        fr_phase = PhHunt;
      end
    endcase
  endtask

  // Out-of-range indexes leave both registers alone.
  task automatic apply_cfg(input logic [1:0] idx, input logic [8:0] val);
    case (idx)
      CfgHeaderByte: cfg_hdr = val[7:0];
      CfgMaxLen:     cfg_max = val;
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic plan_byte(input logic [7:0] b);
    plan_entry_t e;
    e.kind = PlanByte;
    e.idx  = '0;
    e.val  = {1'b0, b};
    e.calm = gen_calm;
    tx_plan.push_back(e);
    gen_sum = gen_sum + b;
    n_planned++;
  endtask

  task automatic plan_cfg(input logic [1:0] idx, input logic [8:0] val);
    plan_entry_t e;
    e.kind = PlanCfg;
    e.idx  = idx;
    e.val  = val;
    e.calm = gen_calm;
    tx_plan.push_back(e);
  endtask

  // The sender holds off here until every outstanding word has come back.
  task automatic plan_pause();
    plan_entry_t e;
    e.kind = PlanPause;
    e.idx  = '0;
    e.val  = '0;
    e.calm = gen_calm;
    tx_plan.push_back(e);
  endtask

  // A frame with random identifiers and payload; keep < 0 sends all of it.
  task automatic plan_frame(input int len, input sum_mode_e mode, input int keep);
    logic [7:0] fb[$];
    logic [7:0] sum;
    int         mx;
    mx = int'(gen_max);
    fb.push_back(gen_hdr);
    sum = gen_hdr;
    repeat (4) begin
      fb.push_back(8'($urandom_range(0, 255)));
      sum = sum + fb[$];
    end
    fb.push_back(len[7:0]);
    sum = sum + len[7:0];
    if (len < mx) begin
      repeat (len) begin
        fb.push_back(8'($urandom_range(0, 255)));
        sum = sum + fb[$];
      end
      case (mode)
        SumGood: fb.push_back(sum);
        SumBad:  fb.push_back(sum ^ (8'd1 << $urandom_range(0, 7)));
        default: fb.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    if (keep < 0 || keep > fb.size()) keep = fb.size();
    for (int i = 0; i < keep; i++) plan_byte(fb[i]);
  endtask

  // Mostly short accepted lengths, now and then a longer one or a rejected one.
  function automatic int pick_len();
    int mx;
    int lim;
    mx  = int'(gen_max);
    lim = (mx >= 256) ? 255 : mx - 1;
    if (lim < 0 || (mx <= 255 && $urandom_range(0, 9) == 0)) return $urandom_range(mx, 255);
    if ($urandom_range(0, 19) == 0) return $urandom_range(0, (lim > 40) ? 40 : lim);
    return $urandom_range(0, (lim > 6) ? 6 : lim);
  endfunction

  // Driver: presents planned bytes and register writes, and keeps the shadow in step.
  always @(posedge clk_i or negedge rst_ni) begin : drive_inputs
    plan_entry_t head;
    logic        byte_busy;
    logic        cfg_busy;
    logic        settled;
    logic        nxt_in_valid;
    logic [7:0]  nxt_byte;
    logic        nxt_cfg_valid;
    logic [1:0]  nxt_cfg_index;
    logic [8:0]  nxt_cfg_data;
    int          nxt_gap;
    int          made;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      data_byte_i  <= '0;
      cfg_valid_i  <= 1'b0;
      cfg_index_i  <= '0;
      cfg_data_i   <= '0;
      send_gap     <= 0;
      quiet_cycles <= 0;
      words_due    <= 0;
      plan_done    <= 1'b0;
      calm_phase   <= 1'b0;
      cfg_hdr      = HeaderByteRst;
      cfg_max      = MaxLenRst;
      fr_phase     = PhHunt;
      fr_count     = '0;
      fr_sum       = '0;
      seen_dev     = '0;
      seen_sys     = '0;
      seen_msg     = '0;
      seen_seq     = '0;
      seen_len     = '0;
    end else begin
      nxt_in_valid  = in_valid_i;
      nxt_byte      = data_byte_i;
      nxt_cfg_valid = cfg_valid_i;
      nxt_cfg_index = cfg_index_i;
      nxt_cfg_data  = cfg_data_i;
      nxt_gap       = send_gap;
      byte_busy     = in_valid_i;
      cfg_busy      = cfg_valid_i;
      made          = 0;
      settled       = (quiet_cycles >= SettleCycles);

      if (in_valid_i && in_ready_o) begin
        track_frame_byte(data_byte_i, made);
        n_bytes++;
        byte_busy    = 1'b0;
        nxt_in_valid = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        apply_cfg(cfg_index_i, cfg_data_i);
        cfg_busy      = 1'b0;
        nxt_cfg_valid = 1'b0;
      end

      // Next item from the plan once both channels are free.
      if (!byte_busy && !cfg_busy) begin
        if (send_gap != 0) begin
          nxt_gap = send_gap - 1;
        end else if (tx_plan.size() != 0) begin
          case (tx_plan[0].kind)
            PlanByte: begin
              head         = tx_plan.pop_front();
              nxt_in_valid = 1'b1;
              nxt_byte     = head.val[7:0];
              calm_phase   <= head.calm;
              if (!head.calm && $urandom_range(0, 9) == 0) nxt_gap = $urandom_range(1, 13);
            end
            PlanCfg: begin
              if (settled) begin
                head          = tx_plan.pop_front();
                nxt_cfg_valid = 1'b1;
                nxt_cfg_index = head.idx;
                nxt_cfg_data  = head.val;
              end
            end
            default: begin
              if (settled) head = tx_plan.pop_front();
            end
          endcase
        end else begin
          plan_done <= 1'b1;
        end
      end

      if (words_due == words_seen && !in_valid_i && !cfg_valid_i) begin
        quiet_cycles <= quiet_cycles + 1;
      end else begin
        quiet_cycles <= 0;
      end
      words_due   <= words_due + made;
      send_gap    <= nxt_gap;
      in_valid_i  <= nxt_in_valid;
      data_byte_i <= nxt_byte;
      cfg_valid_i <= nxt_cfg_valid;
      cfg_index_i <= nxt_cfg_index;
      cfg_data_i  <= nxt_cfg_data;
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // Monitor: takes result words, compares them with the oldest expectation, and stalls.
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    bfp_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall  <= 0;
      words_seen  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        words_seen <= words_seen + 1;
        if (expected_words.size() == 0) begin
          $error("result word with no expectation waiting, kind %0d", result_kind_o);
          err_cnt++;
        end else begin
          want = expected_words.pop_front();
          check_field("result_kind", 8'(want.kind), 8'(result_kind_o));
          check_field("payload_byte", want.payload_byte, payload_byte_o);
          check_field("payload_index", want.payload_index, payload_index_o);
          check_field("node_id", want.node_id, node_id_o);
          check_field("net_id", want.net_id, net_id_o);
          check_field("message_id", want.message_id, message_id_o);
          check_field("sequence_number", want.sequence_number, sequence_number_o);
          check_field("frame_payload_len", want.frame_payload_len, frame_payload_len_o);
          check_field("received_checksum", want.received_checksum, received_checksum_o);
          check_field("computed_checksum", want.computed_checksum, computed_checksum_o);
          check_field("frame_status", 8'(want.frame_status), 8'(frame_status_o));
          if (want.kind == KindPayload) n_payload++;
          else if (want.frame_status == StatusOk) n_ok++;
          else if (want.frame_status == StatusMismatch) n_bad++;
          else n_rej++;
        end
      end

      // Stall bursts of random length hold the result channel back.
      if (recv_stall != 0) begin
        recv_stall  <= recv_stall - 1;
        out_ready_i <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
        recv_stall  <= $urandom_range(0, 12);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Build the plan, release reset, and judge the run once it has drained.
  initial begin : run_control
    int goal;
    int pick;
    int len;
    gen_calm  = 1'b0;
    gen_hdr   = HeaderByteRst;
    gen_max   = MaxLenRst;
    gen_sum   = '0;
    n_planned = 0;

    // Noise while hunting, which the block ignores.
    plan_byte(8'h00);
    plan_byte(8'hFF);
    // Zero length, with the header value among the identifiers, good checksum.
    gen_sum = '0;
    plan_byte(gen_hdr);
    plan_byte(8'h00);
    plan_byte(8'hFF);
    plan_byte(gen_hdr);
    plan_byte(8'h55);
    plan_byte(8'h00);
    plan_byte(gen_sum);
    // One payload byte at the top value, wrong checksum.
    gen_sum = '0;
    plan_byte(gen_hdr);
    plan_byte(8'hFF);
    plan_byte(8'h00);
    plan_byte(8'h01);
    plan_byte(8'h80);
    plan_byte(8'h01);
    plan_byte(8'hFF);
    plan_byte(~gen_sum);
    // Length equal to the maximum is rejected on the length byte.
    plan_byte(gen_hdr);
    plan_byte(8'h12);
    plan_byte(8'h34);
    plan_byte(8'h56);
    plan_byte(8'h78);
    plan_byte(gen_max[7:0]);

    // Random phases, each under its own register setting.
    for (int p = 0; p < 10; p++) begin
      plan_pause();
      case (p)
        0: begin
          gen_hdr = 8'h00;
          gen_max = 9'd256;
        end
        1: begin
          gen_hdr = 8'hFF;
          gen_max = 9'd1;
        end
        2: begin
          gen_hdr = 8'($urandom_range(0, 255));
          gen_max = 9'd0;
        end
        3: begin
          gen_hdr = 8'($urandom_range(0, 255));
          gen_max = 9'h1FF;
        end
        default: begin
          gen_hdr = 8'($urandom_range(0, 255));
          gen_max = 9'($urandom_range(1, 256));
        end
      endcase
      if ($urandom_range(0, 1) == 1) begin
        plan_cfg(CfgMaxLen, gen_max);
        plan_cfg(CfgHeaderByte, {1'b0, gen_hdr});
      end else begin
        plan_cfg(CfgHeaderByte, {1'b0, gen_hdr});
        plan_cfg(CfgMaxLen, gen_max);
      end
      if (p == 3) begin
        plan_cfg(CfgUnusedLo, 9'($urandom_range(0, 511)));
        plan_cfg(CfgUnusedHi, 9'($urandom_range(0, 511)));
      end
      if (p == 0) plan_frame(255, SumGood, -1);

      goal = n_planned + 40;
      while (n_planned < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          repeat ($urandom_range(1, 3)) plan_byte(8'($urandom_range(0, 255)));
        end else if (pick < 14) begin
          len = pick_len();
          plan_frame(len, SumGood, $urandom_range(1, 6 + len));
        end else if (pick < 17) begin
          plan_pause();
        end else begin
          plan_frame(pick_len(), (pick < 75) ? SumGood : ((pick < 92) ? SumBad : SumAny), -1);
        end
      end
      // Leave a frame open so that the next register write lands in the middle of it.
      if ($urandom_range(0, 1) == 1) plan_frame(pick_len(), SumGood, $urandom_range(2, 6));
    end

    // Closing stretch at full rate on both sides.
    plan_pause();
    gen_hdr = HeaderByteRst;
    gen_max = MaxLenRst;
    plan_cfg(CfgHeaderByte, {1'b0, gen_hdr});
    plan_cfg(CfgMaxLen, gen_max);
    gen_calm = 1'b1;
    goal = n_planned + 60;
    while (n_planned < goal) begin
      plan_frame(pick_len(), ($urandom_range(0, 4) == 0) ? SumBad : SumGood, -1);
    end
    plan_pause();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (plan_done);
    repeat (SettleCycles) @(posedge clk_i);
    if (expected_words.size() != 0) begin
      $error("%0d expected result words never arrived", expected_words.size());
      err_cnt += expected_words.size();
    end

    $display("Sent %0d bytes and %0d register writes over 12 register settings.",
             n_bytes, n_cfg);
    $display("Checked %0d payload words and verdicts: %0d ok, %0d mismatch, %0d rejected.",
             n_payload, n_ok, n_bad, n_rej);
    if (err_cnt == 0) begin
      $display("binary_frame_parser regression: pass");
    end else begin
      $display("binary_frame_parser regression: fail");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("binary_frame_parser regression: fail");
    $finish;
  end

endmodule
